// ----- design/line_junction_classifier_fsm_macros.svh -----
// Assertion macros for the line junction classifier.
`ifndef LINE_JUNCTION_CLASSIFIER_FSM_MACROS_SVH
`define LINE_JUNCTION_CLASSIFIER_FSM_MACROS_SVH

`ifndef ASSERT_OFF
`define LJC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LJC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LJC_ASSERT(lbl, prop, msg)
`define LJC_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ----- design/ljc_pkg.sv -----
// Types and constants shared by the line junction classifier.
package ljc_pkg;

  parameter int unsigned CONFIRM_TICKS = 2;
  parameter int unsigned WAIT_W        = $clog2(CONFIRM_TICKS + 2);
  parameter logic [WAIT_W-1:0] CONFIRM_LAST = WAIT_W'(CONFIRM_TICKS);

  parameter int unsigned SPEED_W   = 8;
  parameter int unsigned CODE_W    = 4;
  parameter int unsigned MODE_W    = 2;
  parameter int unsigned CFG_IDX_W = 2;

  typedef enum logic [CODE_W-1:0] {
    PATH_NONE     = 4'd0,
    PATH_STRAIGHT = 4'd1,
    PATH_EXPECT   = 4'd2,
    PATH_CONFIRM  = 4'd3,
    PATH_LEFT     = 4'd4,
    PATH_RIGHT    = 4'd5,
    PATH_DEAD     = 4'd6,
    PATH_T        = 4'd7,
    PATH_LBRANCH  = 4'd8,
    PATH_RBRANCH  = 4'd9,
    PATH_CROSS    = 4'd10,
    PATH_PENDING  = 4'd11
  } path_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_OTHER      = 2'd0,
    MODE_TURN_RIGHT = 2'd1,
    MODE_TURN_LEFT  = 2'd2,
    MODE_SPARE      = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONFIRMING_SPEED = 2'd0,
    CFG_EXPECTING_SPEED  = 2'd1,
    CFG_DEFAULT_SPEED    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              right_side;
    logic              left_side;
    logic              right_ahead;
    logic              left_ahead;
    logic              centre_line;
    logic [MODE_W-1:0] motion_mode;
  } ljc_in_t;

  typedef struct packed {
    logic               go_forward;
    logic               go_left;
    logic               go_right;
    logic [SPEED_W-1:0] speed;
    logic [CODE_W-1:0]  path_code;
  } ljc_out_t;

  typedef struct packed {
    path_e             present;
    path_e             queued;
    logic [WAIT_W-1:0] wait_cnt;
    logic              right_seen;
    logic              left_seen;
  } ljc_state_t;

  typedef struct packed {
    logic [SPEED_W-1:0] confirming;
    logic [SPEED_W-1:0] expecting;
    logic [SPEED_W-1:0] fallback;
  } ljc_speed_t;

endpackage

// ----- design/ljc_sensor_if.sv -----
// Sensor sample channel: valid/ready plus the five line bits and motion mode.
interface ljc_sensor_if;
  import ljc_pkg::*;

  logic              valid;
  logic              ready;
  logic              right_side;
  logic              left_side;
  logic              right_ahead;
  logic              left_ahead;
  logic              centre_line;
  logic [MODE_W-1:0] motion_mode;

  modport source (
    output valid, right_side, left_side, right_ahead, left_ahead, centre_line,
           motion_mode,
    input  ready
  );

  modport sink (
    input  valid, right_side, left_side, right_ahead, left_ahead, centre_line,
           motion_mode,
    output ready
  );
endinterface

// ----- design/ljc_path_if.sv -----
// Path result channel: valid/ready plus directions, speed and path code.
interface ljc_path_if;
  import ljc_pkg::*;

  logic               valid;
  logic               ready;
  logic               go_forward;
  logic               go_left;
  logic               go_right;
  logic [SPEED_W-1:0] speed;
  logic [CODE_W-1:0]  path_code;

  modport source (
    output valid, go_forward, go_left, go_right, speed, path_code,
    input  ready
  );

  modport sink (
    input  valid, go_forward, go_left, go_right, speed, path_code,
    output ready
  );
endinterface

// ----- design/ljc_classify.sv -----
// Path classification: next state and result for one sensor beat.
module ljc_classify (
  input  ljc_pkg::ljc_state_t state_i,
  input  ljc_pkg::ljc_in_t    item_i,
  input  ljc_pkg::ljc_speed_t speed_i,
  output ljc_pkg::ljc_state_t state_o,
  output ljc_pkg::ljc_out_t   result_o
);
  import ljc_pkg::*;

  logic              ahead;
  logic              leave;
  path_e             p1_path;
  path_e             q1_path;
  path_e             p2_path;
  path_e             q2_path;
  path_e             decision;
  logic [WAIT_W-1:0] wait_inc;
  logic              rseen_nx;
  logic              lseen_nx;

  assign ahead = item_i.right_ahead | item_i.left_ahead;

  // ahead sensors that end a held path, gated by turn direction
  always_comb begin
    unique case (mode_e'(item_i.motion_mode))
      MODE_TURN_RIGHT: leave = item_i.right_ahead;
      MODE_TURN_LEFT:  leave = item_i.left_ahead;
      default:         leave = ahead;
    endcase
  end

  // first pass: classify or leave
  always_comb begin
    p1_path = state_i.present;
    q1_path = state_i.queued;
    if (state_i.queued == PATH_NONE && state_i.present != PATH_CONFIRM) begin
      if (ahead) begin
        priority if (item_i.right_side && item_i.left_side) p1_path = PATH_CROSS;
        else if (item_i.right_side)                         p1_path = PATH_RBRANCH;
        else if (item_i.left_side)                          p1_path = PATH_LBRANCH;
        else                                                p1_path = PATH_STRAIGHT;
      end else begin
        p1_path = PATH_EXPECT;
      end
    end else if (leave) begin
      p1_path = PATH_STRAIGHT;
      q1_path = PATH_NONE;
    end
  end

  assign wait_inc = (state_i.wait_cnt <= CONFIRM_LAST) ?
                    state_i.wait_cnt + WAIT_W'(1) : state_i.wait_cnt;
  assign rseen_nx = state_i.right_seen | item_i.right_side;
  assign lseen_nx = state_i.left_seen | item_i.left_side;

  always_comb begin
    priority if (ahead) begin
      priority if (rseen_nx && lseen_nx) decision = PATH_CROSS;
      else if (rseen_nx)                 decision = PATH_RBRANCH;
      else if (lseen_nx)                 decision = PATH_LBRANCH;
      else                               decision = PATH_CONFIRM;
    end else begin
      priority if (rseen_nx && lseen_nx) decision = PATH_T;
      else if (rseen_nx)                 decision = PATH_RIGHT;
      else if (lseen_nx)                 decision = PATH_LEFT;
      else                               decision = PATH_CONFIRM;
    end
  end

  // next state
  always_comb begin
    p2_path          = p1_path;
    q2_path          = q1_path;
    state_o.wait_cnt   = state_i.wait_cnt;
    state_o.right_seen = state_i.right_seen;
    state_o.left_seen  = state_i.left_seen;
    unique case (p1_path)
      PATH_EXPECT: begin
        priority if (item_i.right_side && item_i.left_side) begin
          q2_path = PATH_T;
        end else if (item_i.right_side) begin
          p2_path            = PATH_CONFIRM;
          state_o.right_seen = 1'b1;
        end else if (item_i.left_side) begin
          p2_path           = PATH_CONFIRM;
          state_o.left_seen = 1'b1;
        end else if (!item_i.centre_line && !ahead) begin
          q2_path = PATH_DEAD;
        end
      end
      PATH_CONFIRM: begin
        if (wait_inc > CONFIRM_LAST) begin
          q2_path            = decision;
          state_o.wait_cnt   = '0;
          state_o.right_seen = 1'b0;
          state_o.left_seen  = 1'b0;
        end else begin
          state_o.wait_cnt   = wait_inc;
          state_o.right_seen = rseen_nx;
          state_o.left_seen  = lseen_nx;
        end
      end
      PATH_T, PATH_LBRANCH, PATH_RBRANCH, PATH_CROSS: begin
        q2_path = PATH_PENDING;
      end
      default: begin
      end
    endcase
    state_o.queued  = q2_path;
    state_o.present = (q2_path != PATH_NONE) ? q2_path : p2_path;
  end

  // outputs
  always_comb begin
    result_o.go_forward = 1'b0;
    result_o.go_left    = 1'b0;
    result_o.go_right   = 1'b0;
    unique case (p1_path)
      PATH_STRAIGHT, PATH_EXPECT, PATH_CONFIRM: result_o.go_forward = 1'b1;
      PATH_LEFT:  result_o.go_left  = 1'b1;
      PATH_RIGHT: result_o.go_right = 1'b1;
      PATH_T: begin
        result_o.go_left  = 1'b1;
        result_o.go_right = 1'b1;
      end
      PATH_LBRANCH: begin
        result_o.go_forward = 1'b1;
        result_o.go_left    = 1'b1;
      end
      PATH_RBRANCH: begin
        result_o.go_forward = 1'b1;
        result_o.go_right   = 1'b1;
      end
      PATH_CROSS: begin
        result_o.go_forward = 1'b1;
        result_o.go_left    = 1'b1;
        result_o.go_right   = 1'b1;
      end
      default: begin
      end
    endcase
    unique case (p2_path)
      PATH_CONFIRM: result_o.speed = speed_i.confirming;
      PATH_EXPECT:  result_o.speed = speed_i.expecting;
      default:      result_o.speed = speed_i.fallback;
    endcase
    result_o.path_code = p2_path;
  end

endmodule

// ----- design/line_junction_classifier_fsm.sv -----
// Line junction classifier top level: beat registers, state, speed registers.
//
//   channel    dir   handshake       beat
//   sensor_i   in    valid / ready   five line bits, motion mode
//   path_o     out   valid / ready   go_forward/left/right, speed, path code
//   cfg        in    cfg_we_i        cfg_idx_i, cfg_wdata_i
//
// One beat per cycle sustained while path_o is ready; a taken beat passes to
// path_o through the input register, classify logic and result register.
// The classify state advances once per beat, when it moves to the result register.
// Reset clears state, speed registers and both valid flags; no sweep needed.
// A stalled path_o holds its beat while one more sensor beat is taken.
`include "line_junction_classifier_fsm_macros.svh"

module line_junction_classifier_fsm (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ljc_sensor_if.sink                      sensor_i,
  ljc_path_if.source                      path_o,
  input  logic                            cfg_we_i,
  input  logic [ljc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ljc_pkg::SPEED_W-1:0]     cfg_wdata_i
);
  import ljc_pkg::*;

  ljc_in_t    in_q;
  logic       in_vld_q;
  ljc_out_t   out_q;
  ljc_out_t   out_d;
  logic       out_vld_q;
  ljc_state_t state_q;
  ljc_state_t state_d;
  ljc_speed_t speed_q;
  logic       adv;
  logic       in_take;

  assign adv     = in_vld_q & (~out_vld_q | path_o.ready);
  assign in_take = sensor_i.valid & sensor_i.ready;

  assign sensor_i.ready = ~in_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (path_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= '{right_side:  sensor_i.right_side,
                left_side:   sensor_i.left_side,
                right_ahead: sensor_i.right_ahead,
                left_ahead:  sensor_i.left_ahead,
                centre_line: sensor_i.centre_line,
                motion_mode: sensor_i.motion_mode};
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{present: PATH_NONE, queued: PATH_NONE, wait_cnt: '0,
                   right_seen: 1'b0, left_seen: 1'b0};
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CONFIRMING_SPEED: speed_q.confirming <= cfg_wdata_i;
        CFG_EXPECTING_SPEED:  speed_q.expecting  <= cfg_wdata_i;
        CFG_DEFAULT_SPEED:    speed_q.fallback   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ljc_classify u_classify (
    .state_i  (state_q),
    .item_i   (in_q),
    .speed_i  (speed_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  assign path_o.valid      = out_vld_q;
  assign path_o.go_forward = out_q.go_forward;
  assign path_o.go_left    = out_q.go_left;
  assign path_o.go_right   = out_q.go_right;
  assign path_o.speed      = out_q.speed;
  assign path_o.path_code  = out_q.path_code;

  `LJC_ASSERT(a_wait_bound, state_q.wait_cnt <= CONFIRM_LAST, "confirm wait count overran")
  `LJC_ASSERT_IMP(a_queue_taken, state_q.queued != PATH_NONE,
                  state_q.present == state_q.queued, "queued path not taken over")
  `LJC_ASSERT(a_adv_loads, adv |=> out_vld_q, "advanced beat lost")
  `LJC_ASSERT_IMP(a_cross_dirs, out_vld_q && out_q.path_code == PATH_CROSS,
                  out_q.go_forward && out_q.go_left && out_q.go_right,
                  "crossroad without all directions")
  `LJC_ASSERT_IMP(a_straight_dirs, out_vld_q && out_q.path_code == PATH_STRAIGHT,
                  out_q.go_forward && !out_q.go_left && !out_q.go_right,
                  "straight with side direction")

endmodule
